// ===== rtl/skf_pkg.sv =====
// Shared constants and types for the speed/acceleration Kalman fusion block.
`timescale 1ns / 1ps
`default_nettype none
package skf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int DT_SHIFT      = 16;
  localparam int IO_BITS       = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int DT_BITS       = 16;
  localparam int NOISE_BITS    = 31;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_STEP   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_QNOISE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_QNOISE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_RNOISE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_RNOISE = 3'd4;

  localparam logic [DT_BITS-1:0]    TIME_STEP_RST    = 16'd66;
  localparam logic [NOISE_BITS-1:0] SPEED_QNOISE_RST = 31'd655;
  localparam logic [NOISE_BITS-1:0] ACCEL_QNOISE_RST = 31'd655;
  localparam logic [NOISE_BITS-1:0] SPEED_RNOISE_RST = 31'd3276800;
  localparam logic [NOISE_BITS-1:0] ACCEL_RNOISE_RST = 31'd65536;

  typedef struct packed {
    logic start;
    logic dt_shift;
  } mul_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/skf_if.sv =====
// Channel interfaces: measurement input, estimate output and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface skf_meas_if import skf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [IO_BITS-1:0] measured_speed;
  logic signed [IO_BITS-1:0] measured_accel;
  modport source(output valid, measured_speed, measured_accel, input ready);
  modport sink(input valid, measured_speed, measured_accel, output ready);
endinterface

interface skf_est_if import skf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [IO_BITS-1:0] speed_estimate;
  logic signed [IO_BITS-1:0] accel_estimate;
  modport source(output valid, speed_estimate, accel_estimate, input ready);
  modport sink(input valid, speed_estimate, accel_estimate, output ready);
endinterface

interface skf_cfg_if import skf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/skf_mul.sv =====
// Bit-serial signed fixed-point multiplier with round-half-away and saturation.
`timescale 1ns / 1ps
`default_nettype none
module skf_mul import skf_pkg::*; #(
  parameter int W = WORD_BITS_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mul_ctl_t            ctl,
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [W-1:0] b,
  output logic                     done,
  output logic signed [W-1:0]      y
);
  localparam int CW = $clog2(W + 1);
  localparam int PW = 2 * W + 1;
  localparam logic [PW-1:0] RND_DT  = PW'(1) << (DT_SHIFT - 1);
  localparam logic [PW-1:0] RND_F   = PW'(1) << (F - 1);
  localparam logic [PW-1:0] LIM_NEG = PW'(1) << (W - 1);
  localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);

  logic          busy_r, fin_r, done_r, neg_r, dts_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  mc_r, hi_r, lo_r;
  logic signed [W-1:0] y_r;

  logic [W-1:0]  mag_a, mag_b, magw;
  logic [W:0]    sum;
  logic [PW-1:0] prod_rnd, shifted, lim, mag;

  always_comb begin
    mag_a    = a[W-1] ? W'(-a) : W'(a);
    mag_b    = b[W-1] ? W'(-b) : W'(b);
    sum      = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mc_r} : '0);
    prod_rnd = {1'b0, hi_r, lo_r} + (dts_r ? RND_DT : RND_F);
    shifted  = dts_r ? (prod_rnd >> DT_SHIFT) : (prod_rnd >> F);
    lim      = neg_r ? LIM_NEG : LIM_POS;
    mag      = (shifted > lim) ? lim : shifted;
    magw     = mag[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= a[W-1] ^ b[W-1];
        dts_r  <= ctl.dt_shift;
        mc_r   <= mag_a;
        lo_r   <= mag_b;
        hi_r   <= '0;
      end else if (busy_r) begin
        // shift-add one multiplier bit
        hi_r  <= sum[W:1];
        lo_r  <= {sum[0], lo_r[W-1:1]};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        y_r    <= neg_r ? -$signed(magw) : $signed(magw);
      end
    end
  end

  assign done = done_r;
  assign y    = y_r;

  property p_done_single;
    @(posedge clk) disable iff (!rst_n) done_r |=> !done_r;
  endproperty
  a_done_single: assert property (p_done_single) else $error("mul done longer than a cycle");

  property p_busy_excl;
    @(posedge clk) disable iff (!rst_n) !(busy_r && fin_r);
  endproperty
  a_busy_excl: assert property (p_busy_excl) else $error("mul iterate and finish overlap");

  property p_fin_after_busy;
    @(posedge clk) disable iff (!rst_n) $rose(fin_r) |-> $past(busy_r);
  endproperty
  a_fin_after_busy: assert property (p_fin_after_busy) else $error("mul finish without iterate");

endmodule
`default_nettype wire

// ===== rtl/skf_div.sv =====
// Bit-serial restoring divider forming the gain p/(p+r) with round-half-up.
`timescale 1ns / 1ps
`default_nettype none
module skf_div import skf_pkg::*; #(
  parameter int W = WORD_BITS_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [W-1:0] p,
  input  wire logic [W-1:0]        r,
  output logic                     done,
  output logic [W-1:0]             gain
);
  localparam int CW = $clog2(F + 1);
  localparam logic [W-1:0] ONE_W = W'(1) << F;

  logic          busy_r, rnd_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [W:0]    rem_r;
  logic [W-1:0]  den_r, g_r;
  logic [F:0]    q_r;

  logic [W:0]   s_sum, shl;
  logic         ge, up;

  always_comb begin
    s_sum = {1'b0, p} + {1'b0, r};
    shl   = {rem_r[W-1:0], 1'b0};
    ge    = shl >= {1'b0, den_r};
    up    = {rem_r, 1'b0} >= {2'b00, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (p[W-1] || p == '0) begin
          done_r <= 1'b1;
          g_r    <= '0;
        end else if (r == '0) begin
          done_r <= 1'b1;
          g_r    <= ONE_W;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          rem_r  <= {1'b0, p};
          den_r  <= s_sum[W-1:0];
          q_r    <= '0;
        end
      end else if (busy_r) begin
        // one quotient bit per cycle
        rem_r <= ge ? (shl - {1'b0, den_r}) : shl;
        q_r   <= {q_r[F-1:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(F - 1)) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end else if (rnd_r) begin
        rnd_r  <= 1'b0;
        done_r <= 1'b1;
        g_r    <= W'(q_r) + W'(up);
      end
    end
  end

  assign done = done_r;
  assign gain = g_r;

  property p_gain_bound;
    @(posedge clk) disable iff (!rst_n) done_r |-> g_r <= ONE_W;
  endproperty
  a_gain_bound: assert property (p_gain_bound) else $error("gain above one");

  property p_start_idle;
    @(posedge clk) disable iff (!rst_n) start |-> (!busy_r && !rnd_r);
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("div started while busy");

  property p_busy_excl;
    @(posedge clk) disable iff (!rst_n) !(busy_r && rnd_r);
  endproperty
  a_busy_excl: assert property (p_busy_excl) else $error("div iterate and round overlap");

endmodule
`default_nettype wire

// ===== rtl/speed_accel_kalman_fusion.sv =====
// Top level: two-state Kalman fusion sequencer around serial multiply and divide units.
//
//  channel | direction | payload                            | handshake
//  in_ch   | sink      | measured_speed, measured_accel     | valid/ready
//  out_ch  | source    | speed_estimate, accel_estimate     | valid/ready
//  cfg_ch  | sink      | index, data                        | valid/ready (ready tied high)
//
// Each item runs through nine products on the shared bit-serial multiplier (one bit a cycle)
// and two gains on the divider; the default word format is Q16.16.
// A gain settled without dividing (p not positive, or r zero) skips the divider's iteration.
// Items are handled one at a time; in_ch.ready is high only while the sequencer idles.
// A finished result sits in the output register and the next item is accepted meanwhile.
// Reset (rst_n low, synchronous) restores register defaults and the initial state.
`timescale 1ns / 1ps
`default_nettype none
module speed_accel_kalman_fusion import skf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  skf_meas_if.sink  in_ch,
  skf_est_if.source out_ch,
  skf_cfg_if.sink   cfg_ch
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int XW = ((W > IO_BITS) ? W : IO_BITS) + 3;
  localparam int NW = (W > NOISE_BITS) ? W : NOISE_BITS;
  localparam logic signed [XW-1:0] WMAX_X = (XW'(1) << (W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] WMIN_X = -WMAX_X - XW'(1);
  localparam logic signed [XW-1:0] OMAX_X = XW'(2147483647);
  localparam logic signed [XW-1:0] OMIN_X = -OMAX_X - XW'(1);
  localparam logic [NW-1:0] WMAX_N = NW'(WMAX_X);
  localparam logic signed [W-1:0] ONE_W = W'(1) << F;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DT2  = 4'd1;
  localparam logic [3:0] S_VEL  = 4'd2;
  localparam logic [3:0] S_OFF  = 4'd3;
  localparam logic [3:0] S_AA2  = 4'd4;
  localparam logic [3:0] S_AA1  = 4'd5;
  localparam logic [3:0] S_KV   = 4'd6;
  localparam logic [3:0] S_KA   = 4'd7;
  localparam logic [3:0] S_UV   = 4'd8;
  localparam logic [3:0] S_UA   = 4'd9;
  localparam logic [3:0] S_CV   = 4'd10;
  localparam logic [3:0] S_CA   = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] x);
    logic signed [W-1:0] res;
    if (x > WMAX_X)      res = W'(WMAX_X);
    else if (x < WMIN_X) res = W'(WMIN_X);
    else                 res = W'(x);
    return res;
  endfunction

  function automatic logic [W-1:0] noise_word(input logic [NOISE_BITS-1:0] r);
    logic [NW-1:0] ext;
    ext = NW'(r);
    if (ext > WMAX_N) ext = WMAX_N;
    return W'(ext);
  endfunction

  function automatic logic signed [IO_BITS-1:0] out32(input logic signed [W-1:0] v);
    logic signed [XW-1:0] xv;
    xv = XW'(v);
    if (xv > OMAX_X)      xv = OMAX_X;
    else if (xv < OMIN_X) xv = OMIN_X;
    return IO_BITS'(xv);
  endfunction

  // configuration registers
  logic [DT_BITS-1:0]    dt_r;
  logic [NOISE_BITS-1:0] qv_r, qa_r, rv_r, ra_r;

  // filter state and per-item scratch
  logic [3:0] state_r, state_nxt;
  logic signed [W-1:0] vel_r, acc_r, cvv_r, cva_r, cav_r, caa_r;
  logic signed [W-1:0] ms_r, ma_r, dt2_r, t1_r, pvv_r, paa_r;
  logic [W-1:0] kv_r, ka_r;
  logic out_valid_r;
  logic signed [IO_BITS-1:0] out_spd_r, out_acc_r;

  logic in_fire, mul_done, div_done, div_start;
  mul_ctl_t mul_ctl;
  logic signed [W-1:0] mul_a, mul_b, mul_y, div_p, dt_w;
  logic [W-1:0] div_r, div_g, qv_w, qa_w, rv_w, ra_w;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign dt_w  = W'(dt_r);
  assign qv_w  = noise_word(qv_r);
  assign qa_w  = noise_word(qa_r);
  assign rv_w  = noise_word(rv_r);
  assign ra_w  = noise_word(ra_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= TIME_STEP_RST;
      qv_r <= SPEED_QNOISE_RST;
      qa_r <= ACCEL_QNOISE_RST;
      rv_r <= SPEED_RNOISE_RST;
      ra_r <= ACCEL_RNOISE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TIME_STEP:    dt_r <= cfg_ch.data[DT_BITS-1:0];
        CFG_SPEED_QNOISE: qv_r <= cfg_ch.data[NOISE_BITS-1:0];
        CFG_ACCEL_QNOISE: qa_r <= cfg_ch.data[NOISE_BITS-1:0];
        CFG_SPEED_RNOISE: rv_r <= cfg_ch.data[NOISE_BITS-1:0];
        CFG_ACCEL_RNOISE: ra_r <= cfg_ch.data[NOISE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // operand select and unit launch
  always_comb begin
    state_nxt       = state_r;
    mul_ctl.start   = 1'b0;
    mul_ctl.dt_shift = 1'b1;
    mul_a           = dt_w;
    mul_b           = dt_w;
    div_start       = 1'b0;
    div_p           = pvv_r;
    div_r           = rv_w;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mul_ctl.start = 1'b1;
          state_nxt     = S_DT2;
        end
      end
      S_DT2: begin
        mul_a = acc_r;
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          state_nxt     = S_VEL;
        end
      end
      S_VEL: begin
        mul_a = sat_x(XW'(cav_r) + XW'(cva_r));
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          state_nxt     = S_OFF;
        end
      end
      S_OFF: begin
        mul_a = caa_r;
        mul_b = dt2_r;
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          state_nxt     = S_AA2;
        end
      end
      S_AA2: begin
        mul_a = caa_r;
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          state_nxt     = S_AA1;
        end
      end
      S_AA1: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = S_KV;
        end
      end
      S_KV: begin
        div_p = paa_r;
        div_r = ra_w;
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = S_KA;
        end
      end
      S_KA: begin
        mul_ctl.dt_shift = 1'b0;
        mul_a = $signed(kv_r);
        mul_b = sat_x(XW'(ms_r) - XW'(vel_r));
        if (div_done) begin
          mul_ctl.start = 1'b1;
          state_nxt     = S_UV;
        end
      end
      S_UV: begin
        mul_ctl.dt_shift = 1'b0;
        mul_a = $signed(ka_r);
        mul_b = sat_x(XW'(ma_r) - XW'(acc_r));
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          state_nxt     = S_UA;
        end
      end
      S_UA: begin
        mul_ctl.dt_shift = 1'b0;
        mul_a = pvv_r;
        mul_b = ONE_W - $signed(kv_r);
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          state_nxt     = S_CV;
        end
      end
      S_CV: begin
        mul_ctl.dt_shift = 1'b0;
        mul_a = paa_r;
        mul_b = ONE_W - $signed(ka_r);
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          state_nxt     = S_CA;
        end
      end
      S_CA: begin
        if (mul_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vel_r <= '0;
      acc_r <= '0;
      cvv_r <= ONE_W;
      cva_r <= '0;
      cav_r <= '0;
      caa_r <= ONE_W;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (in_fire) begin
        ms_r <= sat_x(XW'(in_ch.measured_speed));
        ma_r <= sat_x(XW'(in_ch.measured_accel));
      end
      if (mul_done) begin
        unique case (state_r)
          S_DT2: dt2_r <= mul_y;
          S_VEL: vel_r <= sat_x(XW'(vel_r) + XW'(mul_y));
          S_OFF: t1_r  <= mul_y;
          S_AA2: begin
            pvv_r <= sat_x(XW'(cvv_r) + XW'(t1_r) + XW'(mul_y) + XW'($signed(qv_w)));
            paa_r <= sat_x(XW'(caa_r) + XW'($signed(qa_w)));
          end
          S_AA1: begin
            cva_r <= sat_x(XW'(cva_r) + XW'(mul_y));
            cav_r <= sat_x(XW'(cav_r) + XW'(mul_y));
          end
          S_UV: vel_r <= sat_x(XW'(vel_r) + XW'(mul_y));
          S_UA: acc_r <= sat_x(XW'(acc_r) + XW'(mul_y));
          S_CV: cvv_r <= mul_y;
          S_CA: caa_r <= mul_y;
          default: ;
        endcase
      end
      if (div_done) begin
        if (state_r == S_KV) kv_r <= div_g;
        else                 ka_r <= div_g;
      end
      if (state_r == S_EMIT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        out_spd_r   <= out32(vel_r);
        out_acc_r   <= out32(acc_r);
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.speed_estimate = out_spd_r;
  assign out_ch.accel_estimate = out_acc_r;

  skf_mul #(.W(W), .F(F)) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .y    (mul_y)
  );

  skf_div #(.W(W), .F(F)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .p    (div_p),
    .r    (div_r),
    .done (div_done),
    .gain (div_g)
  );

  property p_mul_done_state;
    @(posedge clk) disable iff (!rst_n)
      mul_done |-> (state_r != S_IDLE && state_r != S_KV && state_r != S_KA
                    && state_r != S_EMIT);
  endproperty
  a_mul_done_state: assert property (p_mul_done_state) else $error("stray multiply result");

  property p_div_done_state;
    @(posedge clk) disable iff (!rst_n) div_done |-> (state_r == S_KV || state_r == S_KA);
  endproperty
  a_div_done_state: assert property (p_div_done_state) else $error("stray gain result");

  property p_emit_loads;
    @(posedge clk) disable iff (!rst_n)
      (state_r == S_EMIT && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE);
  endproperty
  a_emit_loads: assert property (p_emit_loads) else $error("result not loaded");

  property p_var_nonneg;
    @(posedge clk) disable iff (!rst_n) (state_r == S_IDLE) |-> (!cvv_r[W-1] && !caa_r[W-1]);
  endproperty
  a_var_nonneg: assert property (p_var_nonneg) else $error("negative variance");

endmodule
`default_nettype wire
